// ----- design/trrt_pkg.sv -----
package trrt_pkg;

  localparam int unsigned WordW = 32;

  // register byte address of chunk_length
  localparam logic [0:0] RegChunkLen = 1'b0;

  // per-cell command broadcast down the chain
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1; // shift right from pos, write segment at pos
  localparam logic [2:0] CMD_SETST   = 3'd2; // set start of cell pos
  localparam logic [2:0] CMD_SETEND  = 3'd3; // set end of cell pos
  localparam logic [2:0] CMD_REMOVE  = 3'd4; // shift left from pos

  typedef struct packed {
    logic [2:0]       cmd;
    logic [WordW-1:0] val_s;
    logic [WordW-1:0] val_e;
  } trrt_cmd_t;

endpackage

// ----- design/trrt_cell.sv -----
module trrt_cell
  import trrt_pkg::*;
#(
  parameter int unsigned IdxW = 4,
  parameter logic [IdxW-1:0] Pos = '0
) (
  input  logic             clk_i,
  input  trrt_cmd_t        cmd_i,
  input  logic [IdxW-1:0]  pos_i,
  input  logic [WordW-1:0] left_s_i,
  input  logic [WordW-1:0] left_e_i,
  input  logic [WordW-1:0] right_s_i,
  input  logic [WordW-1:0] right_e_i,
  output logic [WordW-1:0] s_o,
  output logic [WordW-1:0] e_o
);

  logic [WordW-1:0] s_q, e_q;
  logic             here, past;

  assign here = (Pos == pos_i);
  assign past = (Pos > pos_i);

  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      CMD_INSERT: begin
        if (here) begin
          s_q <= cmd_i.val_s;
          e_q <= cmd_i.val_e;
        end else if (past) begin
          s_q <= left_s_i;
          e_q <= left_e_i;
        end
      end
      CMD_SETST:  if (here) s_q <= cmd_i.val_s;
      CMD_SETEND: if (here) e_q <= cmd_i.val_e;
      CMD_REMOVE: begin
        if (here || past) begin
          s_q <= right_s_i;
          e_q <= right_e_i;
        end
      end
      default: ;
    endcase
  end

  assign s_o = s_q;
  assign e_o = e_q;

endmodule

// ----- design/tcp_reassembly_range_tracker_core.sv -----
// channel | dir | handshake           | payload
// s_axis  | in  | tvalid/tready       | segment: seq_num, flow_start_seq, flow_known, payload_len
// m_axis  | out | tvalid/tready       | result: dup_bytes_added, new_data, complete, overflow
// apb     | in  | psel/penable/pready | chunk_length at address 0
//
// one segment at a time: an unknown flow gives its result at the transfer edge
// otherwise transfer cycle, walk to the deciding block, merge, end fix, done,
// in that order, stepped by the walk/merge sequencer
// reset empties the list and clears chunk_length; the range cells need no reset
// a finished result sits in the output register; the next segment is taken once
// that register is free or being drained in the same cycle
module tcp_reassembly_range_tracker_core
  import trrt_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] seq_num, [63:32] flow_start_seq, [79:64] payload_len
  input  logic [79:0] s_axis_tdata_i,
  // [0] flow_known
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] dup_bytes_added, [32] new_data, [33] complete, [34] overflow, [39:35] zero
  output logic [39:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CntW = $clog2(MAX_RANGES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_RANGES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_MERGE = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;
  localparam logic [2:0] ST_FIX   = 3'd4;

  // config register
  logic [30:0] chunk_len_q;
  assign pready = 1'b1;
  assign prdata = {1'b0, chunk_len_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chunk_len_q <= '0;
    else if (psel && penable && pwrite && (paddr == RegChunkLen)) chunk_len_q <= pwdata[30:0];
  end

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d, idx_q, idx_d;
  logic [WordW-1:0] off_q, off_d, endp_q, endp_d, dup_q, dup_d;
  logic [15:0]      len_q, len_d;
  logic             dupl_q, dupl_d, ovf_q, ovf_d;
  logic             ov_q, ov_d;
  logic [34:0]      res_q, res_d;
  trrt_cmd_t        cmd;
  logic [IdxW-1:0]  pos;

  // range cells
  logic [WordW-1:0] cs [MAX_RANGES];
  logic [WordW-1:0] ce [MAX_RANGES];
  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    trrt_cell #(.IdxW(IdxW), .Pos(IdxW'(g))) u_cell (
      .clk_i, .cmd_i(cmd), .pos_i(pos),
      .left_s_i (cs[(g == 0) ? 0 : g - 1]), .left_e_i (ce[(g == 0) ? 0 : g - 1]),
      .right_s_i(cs[(g == MAX_RANGES - 1) ? g : g + 1]),
      .right_e_i(ce[(g == MAX_RANGES - 1) ? g : g + 1]),
      .s_o(cs[g]), .e_o(ce[g])
    );
  end

  // cell at the walk index, and the cell after it for merging
  logic [IdxW-1:0]  ix, ix1;
  logic [WordW-1:0] s_cur, e_cur, s_nxt, e_nxt, e_first;
  assign ix      = idx_q[IdxW-1:0];
  assign ix1     = IdxW'(idx_q + CntW'(1));
  assign s_cur   = cs[ix];
  assign e_cur   = ce[ix];
  assign s_nxt   = cs[ix1];
  assign e_nxt   = ce[ix1];
  assign e_first = ce[0] - cs[0];

  // completion check on the list as it stands in the done cycle
  logic cmp;
  assign cmp = !dupl_q && (cnt_q != '0) && (e_first >= {1'b0, chunk_len_q});

  logic take;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!ov_q || m_axis_tready_i);
  assign take            = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {5'd0, res_q};

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q;
    off_d = off_q; endp_d = endp_q; dup_d = dup_q; len_d = len_q;
    dupl_d = dupl_q; ovf_d = ovf_q; res_d = res_q;
    ov_d = ov_q && !m_axis_tready_i;
    cmd = '{cmd: CMD_NONE, val_s: off_q, val_e: endp_q};
    pos = ix;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          off_d  = s_axis_tdata_i[31:0] - s_axis_tdata_i[63:32];
          endp_d = s_axis_tdata_i[31:0] - s_axis_tdata_i[63:32]
                   + {16'd0, s_axis_tdata_i[79:64]};
          len_d  = s_axis_tdata_i[79:64];
          dup_d = '0; dupl_d = 1'b0; ovf_d = 1'b0; idx_d = '0;
          if (s_axis_tuser_i) state_d = ST_WALK;
          else begin
            res_d = '0; ov_d = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (idx_q >= cnt_q) begin
          if (cnt_q >= MaxCnt) ovf_d = 1'b1;
          else begin
            cmd.cmd = CMD_INSERT; cnt_d = cnt_q + CntW'(1);
          end
          state_d = ST_DONE;
        end else if (off_q < s_cur) begin
          if (endp_q == s_cur) cmd.cmd = CMD_SETST;
          else if (endp_q < s_cur) begin
            if (cnt_q >= MaxCnt) ovf_d = 1'b1;
            else begin
              cmd.cmd = CMD_INSERT; cnt_d = cnt_q + CntW'(1);
            end
          end else begin
            cmd.cmd = CMD_SETST;
            dup_d = dup_q + {16'd0, len_q} - (s_cur - off_q);
          end
          state_d = ST_DONE;
        end else if (off_q <= e_cur) begin
          if (endp_q > e_cur) begin
            cmd.cmd = CMD_SETEND;
            dup_d = dup_q + (e_cur - off_q);
            state_d = ST_MERGE;
          end else begin
            dupl_d = 1'b1; dup_d = dup_q + {16'd0, len_q};
            state_d = ST_DONE;
          end
        end else idx_d = idx_q + CntW'(1);
      end
      ST_MERGE: begin
        // endp_q mirrors the current block's end
        if ((idx_q + CntW'(1) < cnt_q) && (s_nxt <= endp_q)) begin
          pos = ix1; cmd.cmd = CMD_REMOVE; cnt_d = cnt_q - CntW'(1);
          if (e_nxt > endp_q) begin
            dup_d = dup_q + (endp_q - s_nxt);
            endp_d = e_nxt;
            state_d = ST_FIX;
          end else dup_d = dup_q + (e_nxt - s_nxt);
        end else state_d = ST_DONE;
      end
      ST_FIX: begin
        // partly covered block: its end becomes the current block's end
        cmd.cmd = CMD_SETEND;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_d = ovf_q ? 35'h4_0000_0000 : {1'b0, cmp, !dupl_q, dup_q};
        ov_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; off_q <= off_d; endp_q <= endp_d; dup_q <= dup_d;
    len_q <= len_d; dupl_q <= dupl_d; ovf_q <= ovf_d; res_q <= res_d;
  end

endmodule
